// ===== rtl/rgb_to_hsv_converter_assert.svh =====
// assertion macros for the rtl, included by rgb_to_hsv_converter
`ifndef RGB_TO_HSV_CONVERTER_ASSERT_SVH
`define RGB_TO_HSV_CONVERTER_ASSERT_SVH

// same-cycle implication, held off during reset
`define RHC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("rhc assertion failed");

// next-cycle implication, held off during reset
`define RHC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("rhc assertion failed");

`endif

// ===== rtl/rhc_pkg.sv =====
package rhc_pkg;

	localparam int COMP_W       = 8;
	localparam int HUE_W        = 9;
	localparam int SAT_W        = 8;
	localparam int NUM_W        = 11;
	localparam int REM_W        = 17;
	localparam int QUO_W        = 9;
	localparam int FRONT_STAGES = 2;
	localparam int DIV_STAGES   = QUO_W;
	localparam int PIPE_STAGES  = FRONT_STAGES + DIV_STAGES + 1;
	localparam int HUE_SCALE    = 60;
	localparam int SAT_SCALE    = 255;
	localparam int HUE_LIMIT    = 360;

	typedef struct packed {
		logic [REM_W-1:0]  hnum;
		logic [REM_W-1:0]  snum;
		logic [COMP_W-1:0] delta;
		logic [COMP_W-1:0] mx;
		logic              grey;
	} front_t;

	typedef struct packed {
		logic [HUE_W-1:0]  hue;
		logic [SAT_W-1:0]  sat;
		logic [COMP_W-1:0] val;
	} hsv_t;

endpackage

// ===== rtl/rgb_to_hsv_converter.sv =====
// an input transfer runs through the front stages, the divider stages and the output register
// throughput: one pixel per cycle while hsv_stall is low, through the 9-stage restoring divider pipeline
// an output stall holds only full stages; bubbles ahead of it keep filling
// reset (arst_n low) clears the stage valid bits; pixel data is not reset
module rgb_to_hsv_converter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          pix_valid,
	output logic                          pix_stall,
	input  logic [rhc_pkg::COMP_W-1:0]    red,
	input  logic [rhc_pkg::COMP_W-1:0]    green,
	input  logic [rhc_pkg::COMP_W-1:0]    blue,
	output logic                          hsv_valid,
	input  logic                          hsv_stall,
	output logic [rhc_pkg::HUE_W-1:0]     hue_deg,
	output logic [rhc_pkg::SAT_W-1:0]     sat,
	output logic [rhc_pkg::COMP_W-1:0]    brightness
);
	import rhc_pkg::*;

	`include "rgb_to_hsv_converter_assert.svh"

	localparam int LAST = PIPE_STAGES - 1;

	logic [PIPE_STAGES-1:0] vld_q;
	logic [PIPE_STAGES-1:0] adv;
	front_t                 front;
	hsv_t                   hsv;

	// a stage loads when it is empty or the stage after it moves on
	always_comb begin
		adv[LAST] = !vld_q[LAST] || !hsv_stall;
		for (int i = LAST - 1; i >= 0; i--) begin
			adv[i] = !vld_q[i] || adv[i+1];
		end
	end

	assign pix_stall = !adv[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) vld_q[0] <= pix_valid;
			for (int i = 1; i < PIPE_STAGES; i++) begin
				if (adv[i]) vld_q[i] <= vld_q[i-1];
			end
		end
	end

	rhc_front u_front (
		.clk   (clk),
		.en    (adv[FRONT_STAGES-1:0]),
		.red   (red),
		.green (green),
		.blue  (blue),
		.front (front)
	);

	rhc_div u_div (
		.clk   (clk),
		.en    (adv[FRONT_STAGES+DIV_STAGES-1:FRONT_STAGES]),
		.front (front),
		.hsv   (hsv)
	);

	// output register parts the divider from the consumer
	always_ff @(posedge clk) begin
		if (adv[LAST]) begin
			hue_deg    <= hsv.hue;
			sat        <= hsv.sat;
			brightness <= hsv.val;
		end
	end

	assign hsv_valid = vld_q[LAST];

	`RHC_ASSERT_IMPL(a_hue_range, clk, arst_n, hsv_valid, hue_deg < HUE_W'(HUE_LIMIT))
	`RHC_ASSERT_IMPL(a_grey_hue, clk, arst_n, hsv_valid && sat == '0, hue_deg == '0)
	`RHC_ASSERT_IMPL(a_black_sat, clk, arst_n, hsv_valid && brightness == '0, sat == '0)
	`RHC_ASSERT_IMPL(a_stall_full, clk, arst_n, pix_stall, hsv_valid && hsv_stall && (&vld_q))
	`RHC_ASSERT_NEXT(a_out_load, clk, arst_n, vld_q[LAST-1] && !hsv_stall, hsv_valid)

endmodule

// ===== rtl/rhc_front.sv =====
module rhc_front (
	input  logic                                clk,
	input  logic [rhc_pkg::FRONT_STAGES-1:0]    en,
	input  logic [rhc_pkg::COMP_W-1:0]          red,
	input  logic [rhc_pkg::COMP_W-1:0]          green,
	input  logic [rhc_pkg::COMP_W-1:0]          blue,
	output rhc_pkg::front_t                     front
);
	import rhc_pkg::*;

	logic [COMP_W-1:0] mx, mn;
	logic [NUM_W-1:0]  d11, r11, g11, b11, num;

	logic [COMP_W-1:0] mx_s1, delta_s1;
	logic [NUM_W-1:0]  num_s1;
	logic              grey_s1;

	always_comb begin
		mx = (red > green) ? red : green;
		if (blue > mx) mx = blue;
		mn = (red < green) ? red : green;
		if (blue < mn) mn = blue;
		d11 = NUM_W'(mx - mn);
		r11 = NUM_W'(red);
		g11 = NUM_W'(green);
		b11 = NUM_W'(blue);
		// red tested first, then blue; wraps cancel out in 11 bits
		if (red == mn) begin
			num = d11 * NUM_W'(3) + b11 - g11;
		end else if (blue == mn) begin
			num = d11 + g11 - r11;
		end else begin
			num = d11 * NUM_W'(5) + r11 - b11;
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			mx_s1    <= mx;
			delta_s1 <= mx - mn;
			num_s1   <= num;
			grey_s1  <= (mx == mn);
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			front.hnum  <= REM_W'(num_s1) * REM_W'(HUE_SCALE);
			front.snum  <= REM_W'(delta_s1) * REM_W'(SAT_SCALE);
			front.delta <= delta_s1;
			front.mx    <= mx_s1;
			front.grey  <= grey_s1;
		end
	end

endmodule

// ===== rtl/rhc_div.sv =====
module rhc_div (
	input  logic                              clk,
	input  logic [rhc_pkg::DIV_STAGES-1:0]    en,
	input  rhc_pkg::front_t                   front,
	output rhc_pkg::hsv_t                     hsv
);
	import rhc_pkg::*;

	// two restoring dividers side by side, one quotient bit per stage
	logic [REM_W-1:0]  hrem_s [DIV_STAGES];
	logic [REM_W-1:0]  srem_s [DIV_STAGES];
	logic [QUO_W-1:0]  hquo_s [DIV_STAGES];
	logic [QUO_W-1:0]  squo_s [DIV_STAGES];
	logic [COMP_W-1:0] dlt_s  [DIV_STAGES];
	logic [COMP_W-1:0] mx_s   [DIV_STAGES];
	logic              grey_s [DIV_STAGES];

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		logic [REM_W-1:0]  hr_in, sr_in, hsh, ssh;
		logic [QUO_W-1:0]  hq_in, sq_in;
		logic [COMP_W-1:0] dl_in, mx_in;
		logic              gr_in;

		if (k == 0) begin : g_first
			assign hr_in = front.hnum;
			assign sr_in = front.snum;
			assign hq_in = '0;
			assign sq_in = '0;
			assign dl_in = front.delta;
			assign mx_in = front.mx;
			assign gr_in = front.grey;
		end else begin : g_next
			assign hr_in = hrem_s[k-1];
			assign sr_in = srem_s[k-1];
			assign hq_in = hquo_s[k-1];
			assign sq_in = squo_s[k-1];
			assign dl_in = dlt_s[k-1];
			assign mx_in = mx_s[k-1];
			assign gr_in = grey_s[k-1];
		end

		assign hsh = REM_W'(dl_in) << (QUO_W - 1 - k);
		assign ssh = REM_W'(mx_in) << (QUO_W - 1 - k);

		always_ff @(posedge clk) begin
			if (en[k]) begin
				if (hr_in >= hsh) begin
					hrem_s[k] <= hr_in - hsh;
					hquo_s[k] <= {hq_in[QUO_W-2:0], 1'b1};
				end else begin
					hrem_s[k] <= hr_in;
					hquo_s[k] <= {hq_in[QUO_W-2:0], 1'b0};
				end
				if (sr_in >= ssh) begin
					srem_s[k] <= sr_in - ssh;
					squo_s[k] <= {sq_in[QUO_W-2:0], 1'b1};
				end else begin
					srem_s[k] <= sr_in;
					squo_s[k] <= {sq_in[QUO_W-2:0], 1'b0};
				end
				dlt_s[k]  <= dl_in;
				mx_s[k]   <= mx_in;
				grey_s[k] <= gr_in;
			end
		end
	end

	// grey pixels divided by zero, so their quotients are dropped here
	always_comb begin
		if (grey_s[DIV_STAGES-1]) begin
			hsv.hue = '0;
			hsv.sat = '0;
		end else begin
			hsv.hue = HUE_W'(hquo_s[DIV_STAGES-1]);
			hsv.sat = squo_s[DIV_STAGES-1][SAT_W-1:0];
		end
		hsv.val = mx_s[DIV_STAGES-1];
	end

endmodule

// ===== bench/rgb_to_hsv_converter_test.sv =====
`timescale 1ns / 100ps

module rgb_to_hsv_converter_test;

	localparam int IDLE_LIMIT = 4000;

	logic                       clk;
	logic                       arst_n     = 1'b0;
	logic                       pix_valid  = 1'b0;
	logic                       pix_stall;
	logic [rhc_pkg::COMP_W-1:0] red        = '0;
	logic [rhc_pkg::COMP_W-1:0] green      = '0;
	logic [rhc_pkg::COMP_W-1:0] blue       = '0;
	logic                       hsv_valid;
	logic                       hsv_stall  = 1'b0;
	logic [rhc_pkg::HUE_W-1:0]  hue_deg;
	logic [rhc_pkg::SAT_W-1:0]  sat;
	logic [rhc_pkg::COMP_W-1:0] brightness;

	rhc_pkg::hsv_t pending_hsv[$];
	int            pixels_sent    = 0;
	int            results_seen   = 0;
	int            mismatches     = 0;
	bit            gaps_on        = 1'b1;
	bit            stalls_on      = 1'b1;
	bit            long_stalls    = 1'b0;

	rgb_to_hsv_converter DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.pix_valid  (pix_valid),
		.pix_stall  (pix_stall),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.hsv_valid  (hsv_valid),
		.hsv_stall  (hsv_stall),
		.hue_deg    (hue_deg),
		.sat        (sat),
		.brightness (brightness)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// exact integer hue, saturation and value of one pixel
	function automatic rhc_pkg::hsv_t hsv_of_pixel(
		input logic [rhc_pkg::COMP_W-1:0] r,
		input logic [rhc_pkg::COMP_W-1:0] g,
		input logic [rhc_pkg::COMP_W-1:0] b
	);
		int unsigned   ri;
		int unsigned   gi;
		int unsigned   bi;
		int unsigned   mx;
		int unsigned   mn;
		int unsigned   delta;
		int unsigned   num;
		rhc_pkg::hsv_t res;
		ri = 32'(r);
		gi = 32'(g);
		bi = 32'(b);
		mx = (ri > gi) ? ri : gi;
		mx = (mx > bi) ? mx : bi;
		mn = (ri < gi) ? ri : gi;
		mn = (mn < bi) ? mn : bi;
		res.val = mx[rhc_pkg::COMP_W-1:0];
		res.hue = '0;
		res.sat = '0;
		if (mx != mn) begin
			delta = mx - mn;
			// sector chosen with red tested first, then blue
			if (ri == mn) begin
				num = 3 * delta + bi - gi;
			end else if (bi == mn) begin
				num = delta + gi - ri;
			end else begin
				num = 5 * delta + ri - bi;
			end
			num = (rhc_pkg::HUE_SCALE * num) / delta;
			res.hue = num[rhc_pkg::HUE_W-1:0];
			num = (rhc_pkg::SAT_SCALE * delta) / mx;
			res.sat = num[rhc_pkg::SAT_W-1:0];
		end
		return res;
	endfunction

	// mostly back to back, some short pauses, the odd long one
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (!gaps_on || roll < 60) begin
			return 0;
		end else if (roll < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	task automatic send_pixel(
		input logic [rhc_pkg::COMP_W-1:0] r,
		input logic [rhc_pkg::COMP_W-1:0] g,
		input logic [rhc_pkg::COMP_W-1:0] b
	);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			pix_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_valid <= 1'b1;
		red       <= r;
		green     <= g;
		blue      <= b;
		do @(posedge clk); while (pix_stall);
		pending_hsv.push_back(hsv_of_pixel(r, g, b));
		pixels_sent++;
	endtask

	// uniform pixels mixed with greys, ties and near-greys
	task automatic send_random_pixels(input int count);
		logic [rhc_pkg::COMP_W-1:0] r;
		logic [rhc_pkg::COMP_W-1:0] g;
		logic [rhc_pkg::COMP_W-1:0] b;
		logic [rhc_pkg::COMP_W-1:0] lvl;
		for (int i = 0; i < count; i++) begin
			r   = 8'($urandom_range(0, 255));
			g   = 8'($urandom_range(0, 255));
			b   = 8'($urandom_range(0, 255));
			lvl = 8'($urandom_range(0, 255));
			case ($urandom_range(0, 7))
				0: begin
					r = lvl;
					g = lvl;
					b = lvl;
				end
				1: begin
					case ($urandom_range(0, 2))
						0: g = r;
						1: b = r;
						default: b = g;
					endcase
				end
				2: begin
					g = lvl ^ 8'($urandom_range(0, 3));
					b = lvl ^ 8'($urandom_range(0, 3));
					r = lvl ^ 8'($urandom_range(0, 3));
				end
				default: ;
			endcase
			send_pixel(r, g, b);
		end
	endtask

	task automatic test_directed_colours();
		send_pixel(8'd0,   8'd0,   8'd0);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd128, 8'd128, 8'd128);
		send_pixel(8'd255, 8'd0,   8'd0);
		send_pixel(8'd0,   8'd255, 8'd0);
		send_pixel(8'd0,   8'd0,   8'd255);
		send_pixel(8'd255, 8'd255, 8'd0);
		send_pixel(8'd0,   8'd255, 8'd255);
		send_pixel(8'd255, 8'd0,   8'd255);
		// hue just short of a full turn
		send_pixel(8'd255, 8'd0,   8'd1);
		send_pixel(8'd1,   8'd0,   8'd0);
		send_pixel(8'd0,   8'd1,   8'd0);
		send_pixel(8'd0,   8'd0,   8'd1);
		send_pixel(8'd255, 8'd254, 8'd254);
		send_pixel(8'd254, 8'd255, 8'd255);
		// tied minimum, red wins the sector choice
		send_pixel(8'd0,   8'd0,   8'd128);
		send_pixel(8'd200, 8'd100, 8'd100);
		send_pixel(8'd100, 8'd200, 8'd100);
		send_pixel(8'd100, 8'd100, 8'd200);
		send_pixel(8'd170, 8'd85,  8'd0);
		send_pixel(8'd85,  8'd170, 8'd0);
		send_pixel(8'd0,   8'd170, 8'd85);
		send_pixel(8'd0,   8'd85,  8'd170);
		send_pixel(8'd85,  8'd0,   8'd170);
		send_pixel(8'd170, 8'd0,   8'd85);
	endtask

	task automatic test_random_stream();
		gaps_on     = 1'b1;
		stalls_on   = 1'b1;
		long_stalls = 1'b0;
		send_random_pixels(1200);
	endtask

	task automatic test_output_backpressure();
		gaps_on     = 1'b1;
		stalls_on   = 1'b1;
		long_stalls = 1'b1;
		send_random_pixels(350);
	endtask

	task automatic test_full_rate();
		gaps_on     = 1'b0;
		stalls_on   = 1'b0;
		long_stalls = 1'b0;
		send_random_pixels(300);
	endtask

	always @(posedge clk) begin : stall_gen
		int   hold = 0;
		logic nxt;
		if (hold > 0) begin
			hold--;
			nxt = 1'b1;
		end else if (stalls_on && $urandom_range(0, 99) < (long_stalls ? 40 : 20)) begin
			hold = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
				: $urandom_range(10, long_stalls ? 60 : 25);
			nxt = 1'b1;
		end else begin
			nxt = 1'b0;
		end
		hsv_stall <= nxt;
	end

	always @(posedge clk) begin : hsv_checker
		rhc_pkg::hsv_t want;
		if (arst_n && hsv_valid && !hsv_stall) begin
			results_seen++;
			if (pending_hsv.size() == 0) begin
				$error("result with nothing pending: hue_deg %0d sat %0d brightness %0d",
					hue_deg, sat, brightness);
				mismatches++;
			end else begin
				want = pending_hsv.pop_front();
				if (hue_deg !== want.hue) begin
					$error("hue_deg: expected %0d, actual %0d", want.hue, hue_deg);
					mismatches++;
				end
				if (sat !== want.sat) begin
					$error("sat: expected %0d, actual %0d", want.sat, sat);
					mismatches++;
				end
				if (brightness !== want.val) begin
					$error("brightness: expected %0d, actual %0d", want.val, brightness);
					mismatches++;
				end
			end
		end
	end

	// ends the run when no transfer happens on either side for too long
	always @(posedge clk) begin : watchdog
		int idle_cycles = 0;
		if (arst_n) begin
			if ((pix_valid && !pix_stall) || (hsv_valid && !hsv_stall)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: %0d results still pending", pending_hsv.size());
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_colours();
		test_random_stream();
		test_output_backpressure();
		test_full_rate();
		pix_valid <= 1'b0;

		while (pending_hsv.size() != 0) @(posedge clk);
		repeat (rhc_pkg::PIPE_STAGES + 4) @(posedge clk);

		$display("%0d pixels sent, %0d results checked, %0d mismatches",
			pixels_sent, results_seen, mismatches);
		$display("covered primaries, greys, tied minima, random stream, back-pressure, full rate");
		if (mismatches == 0 && pending_hsv.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
